[rtl/sdrrip_pkg.sv]
// ----------------------------------------------------------------------------
// sdrrip_pkg
// Shared types and constants of the SHiP/DRRIP dead-block replacement unit.
// ----------------------------------------------------------------------------
package sdrrip_pkg;

  localparam int ADDR_W   = 48;
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int MASK_W   = 16;
  localparam int CFG_W    = 20;
  localparam int TICK_W   = 5;

  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] RRPV_NEAR = 2'd0;
  localparam logic [1:0] CNT_MAX   = 2'd3;
  localparam logic [1:0] REUSE_RST = 2'd1;

  localparam logic [ADDR_W-1:0] STRIDE_ONE = 48'd64;
  localparam logic [ADDR_W-1:0] STRIDE_TWO = 48'd128;

  localparam logic [CFG_W-1:0] DECAY_PERIOD_RST = 20'd100000;
  localparam logic [1:0]       STREAM_THR_RST   = 2'd2;

  typedef enum logic {
    CMD_VICTIM = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_code_t;

  typedef enum logic {
    CFG_DECAY_PERIOD = 1'b0,
    CFG_STREAM_THR   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    cmd_code_t           command;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic [MASK_W-1:0]   valid_mask;
    logic [ADDR_W-1:0]   program_counter;
    logic [ADDR_W-1:0]   physical_address;
    logic                hit;
  } in_word_t;

  typedef struct packed {
    logic [WAY_IN_W-1:0] victim_way;
    logic                set_streaming;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear_step;
    logic sweep_rst;
    logic victim_done;
    logic upd_exec;
    logic upd_mod;
    logic upd_done;
    logic decay_step;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_update;
    logic out_busy;
    logic clear_last;
    logic sweep_done;
    logic decay_due;
  } dp_sts_t;

endpackage

[rtl/sdrrip_ram.sv]
// ----------------------------------------------------------------------------
// sdrrip_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sdrrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sdrrip_ctrl.sv]
// ----------------------------------------------------------------------------
// sdrrip_ctrl
// Sequencer: clearing pass, per-command phases and decay sweep.
// ----------------------------------------------------------------------------
module sdrrip_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdrrip_pkg::dp_sts_t sts,
  output sdrrip_pkg::ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MOD,
    ST_DONE,
    ST_DECAY
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          cmd.sweep_rst = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.is_update) begin
          cmd.upd_exec = 1'b1;
          state_nxt    = ST_MOD;
        end else if (!sts.out_busy) begin
          cmd.victim_done = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_MOD: begin
        cmd.upd_mod = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.upd_done = 1'b1;
          if (sts.decay_due) begin
            cmd.sweep_rst = 1'b1;
            state_nxt     = ST_DECAY;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DECAY: begin
        cmd.decay_step = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/sdrrip_dp.sv]
// ----------------------------------------------------------------------------
// sdrrip_dp
// Datapath: line, set and reuse stores, victim search, update logic, sweeps.
// ----------------------------------------------------------------------------
module sdrrip_dp #(
  parameter int SETS           = 2048,
  parameter int WAYS           = 16,
  parameter int LEADER_SETS    = 64,
  parameter int SELECTOR_BITS  = 10,
  parameter int SIGNATURE_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sdrrip_pkg::ctl_cmd_t  cmd,
  output sdrrip_pkg::dp_sts_t   sts,
  input  sdrrip_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sdrrip_pkg::out_word_t out_data,
  input  logic                  cfg_we,
  input  sdrrip_pkg::cfg_idx_t  cfg_index,
  input  logic [sdrrip_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int SET_W     = $clog2(SETS);
  localparam int WAY_W     = $clog2(WAYS);
  localparam int SIG_W     = SIGNATURE_BITS;
  localparam int SIG_COUNT = 1 << SIG_W;
  localparam int SEL_W     = SELECTOR_BITS;
  localparam int LINE_W    = 4 + SIG_W;
  localparam int ROW_W     = WAYS * LINE_W;
  localparam int REC_W     = sdrrip_pkg::ADDR_W + 2;
  localparam int SWEEP_LEN = (SETS > SIG_COUNT) ? SETS : SIG_COUNT;
  localparam int SWP_W     = $clog2(SWEEP_LEN) + 1;
  localparam logic [SEL_W-1:0] SEL_MAX  = '1;
  localparam logic [SEL_W-1:0] SEL_HALF = SEL_W'(1) << (SEL_W - 1);

  // captured word
  sdrrip_pkg::in_word_t in_r;
  logic [SET_W-1:0] set_idx;
  logic [5:0]       way_red;
  logic [WAY_W-1:0] way_idx;
  logic [SIG_W-1:0] sig_cur;
  logic [WAYS-1:0]  vbit;

  // stores
  logic             row_we, set_we, reu_we;
  logic [SET_W-1:0] row_waddr, row_raddr, set_waddr;
  logic [SIG_W-1:0] reu_waddr, reu_raddr;
  logic [ROW_W-1:0] row_wdata, row_rd;
  logic [REC_W-1:0] set_wdata, set_rd;
  logic [1:0]       reu_wdata, reu_rd;

  logic [WAYS-1:0][1:0]       rrpv_q, dead_q;
  logic [WAYS-1:0][SIG_W-1:0] sig_q;

  // sweep
  logic [SWP_W-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic             pend_r, pend_nxt;

  // config and global counters
  logic [sdrrip_pkg::CFG_W-1:0]  period_r;
  logic [1:0]                    thr_r;
  logic [SEL_W-1:0]              sel_r, sel_nxt;
  logic [sdrrip_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [sdrrip_pkg::CFG_W-1:0]  cd_r;
  logic [sdrrip_pkg::CFG_W:0]    cd_inc;
  logic                          decay_due;

  // victim search
  logic             inv_hit, dead_hit;
  logic [WAY_W-1:0] inv_way, dead_way, age_way, vict_way;
  logic             any3, any2, any1;
  logic [1:0]       top, add;
  logic [WAYS-1:0][1:0] aged;

  // stream detector
  logic [sdrrip_pkg::ADDR_W-1:0] last_q, delta;
  logic [1:0] score_q, score_new;
  logic       streaming, streaming_r;

  // reuse and line update
  logic [SIG_W-1:0] tgt, tgt_r;
  logic [1:0] reu_mod, reu_mod_r, sig_val, dead0, dead1, ins, rrpv_new, dead_new;
  logic       leader, brrip_leader, brrip;
  logic [WAYS-1:0][1:0]       rrpv_w, dead_w, dead_dec;
  logic [WAYS-1:0][SIG_W-1:0] sig_w;

  logic                  out_valid_r;
  sdrrip_pkg::out_word_t out_data_r;

  // ---------------- captured word decode ----------------
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
  end

  if (SET_W <= sdrrip_pkg::SET_IN_W) begin : g_set_trunc
    assign set_idx = in_r.set_index[SET_W-1:0];
  end else begin : g_set_ext
    assign set_idx = {{(SET_W-sdrrip_pkg::SET_IN_W){1'b0}}, in_r.set_index};
  end

  // way_index modulo WAYS; at most eight subtractions for WAYS >= 2
  always_comb begin
    way_red = {2'b00, in_r.way_index};
    for (int i = 0; i < 8; i++) begin
      if (way_red >= 6'(WAYS)) begin
        way_red = way_red - 6'(WAYS);
      end
    end
  end
  assign way_idx = way_red[WAY_W-1:0];
  assign sig_cur = in_r.program_counter[SIG_W+1:2];

  for (genvar g = 0; g < WAYS; g++) begin : g_vbit
    if (g < sdrrip_pkg::MASK_W) begin : g_in
      assign vbit[g] = in_r.valid_mask[g];
    end else begin : g_out
      assign vbit[g] = 1'b0;
    end
  end

  assign {sig_q, dead_q, rrpv_q} = row_rd;
  assign last_q  = set_rd[REC_W-1:2];
  assign score_q = set_rd[1:0];

  // ---------------- victim search ----------------
  always_comb begin
    inv_hit  = 1'b0;
    inv_way  = '0;
    dead_hit = 1'b0;
    dead_way = '0;
    age_way  = '0;
    any3     = 1'b0;
    any2     = 1'b0;
    any1     = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      any3 = any3 | (rrpv_q[w] == 2'd3);
      any2 = any2 | (rrpv_q[w] == 2'd2);
      any1 = any1 | (rrpv_q[w] == 2'd1);
    end
    top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
    add = sdrrip_pkg::RRPV_MAX - top;
    for (int w = 0; w < WAYS; w++) begin
      aged[w] = rrpv_q[w] + add;
    end
    // descending scan: lowest matching way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vbit[w]) begin
        inv_hit = 1'b1;
        inv_way = WAY_W'(w);
      end
      if (dead_q[w] == sdrrip_pkg::CNT_MAX) begin
        dead_hit = 1'b1;
        dead_way = WAY_W'(w);
      end
      if (aged[w] == sdrrip_pkg::RRPV_MAX) begin
        age_way = WAY_W'(w);
      end
    end
    vict_way = inv_hit ? inv_way : dead_hit ? dead_way : age_way;
  end

  // ---------------- stream detector ----------------
  always_comb begin
    delta = (in_r.physical_address > last_q) ? (in_r.physical_address - last_q)
                                             : (last_q - in_r.physical_address);
    if (last_q == '0) begin
      score_new = 2'd0;
    end else if (delta == sdrrip_pkg::STRIDE_ONE || delta == sdrrip_pkg::STRIDE_TWO) begin
      score_new = (score_q == 2'd3) ? score_q : score_q + 2'd1;
    end else begin
      score_new = (score_q == 2'd0) ? score_q : score_q - 2'd1;
    end
    streaming = score_new >= thr_r;
  end

  // ---------------- reuse and line update ----------------
  assign tgt     = in_r.hit ? sig_cur : sig_q[way_idx];
  assign reu_mod = in_r.hit ? ((reu_rd == 2'd3) ? reu_rd : reu_rd + 2'd1)
                            : ((reu_rd == 2'd0) ? reu_rd : reu_rd - 2'd1);
  assign sig_val = (tgt_r == sig_cur) ? reu_mod_r : reu_rd;

  assign leader       = 32'(set_idx) < 32'(LEADER_SETS);
  assign brrip_leader = 32'(set_idx) >= 32'(LEADER_SETS / 2);

  always_comb begin
    sel_nxt = sel_r;
    if (leader && !brrip_leader && in_r.hit && sel_r != SEL_MAX) begin
      sel_nxt = sel_r + SEL_W'(1);
    end else if (leader && brrip_leader && !in_r.hit && sel_r != '0) begin
      sel_nxt = sel_r - SEL_W'(1);
    end
    tick_nxt = tick_r + sdrrip_pkg::TICK_W'(1);
    brrip    = leader ? brrip_leader : (sel_nxt < SEL_HALF);

    dead0 = dead_q[way_idx];
    dead1 = in_r.hit ? 2'd0 : ((dead0 == sdrrip_pkg::CNT_MAX) ? dead0 : dead0 + 2'd1);
    ins   = (brrip && tick_nxt == '0) ? sdrrip_pkg::RRPV_MAX : sdrrip_pkg::RRPV_LONG;
    if (sig_val >= 2'd2) begin
      ins = sdrrip_pkg::RRPV_NEAR;
    end
    if (dead1 >= 2'd2) begin
      ins = sdrrip_pkg::RRPV_MAX;
    end
    if (streaming_r) begin
      rrpv_new = sdrrip_pkg::RRPV_MAX;
      dead_new = sdrrip_pkg::CNT_MAX;
    end else begin
      rrpv_new = ins;
      dead_new = (ins == sdrrip_pkg::RRPV_NEAR) ? 2'd0 : dead1;
    end
    rrpv_w = rrpv_q;
    dead_w = dead_q;
    sig_w  = sig_q;
    rrpv_w[way_idx] = rrpv_new;
    dead_w[way_idx] = dead_new;
    sig_w[way_idx]  = sig_cur;
    for (int w = 0; w < WAYS; w++) begin
      dead_dec[w] = (dead_q[w] == 2'd0) ? dead_q[w] : dead_q[w] - 2'd1;
    end
  end

  assign cd_inc    = {1'b0, cd_r} + (sdrrip_pkg::CFG_W + 1)'(1);
  assign decay_due = cd_inc >= {1'b0, period_r};

  always_ff @(posedge clk) begin
    if (cmd.upd_exec) begin
      tgt_r       <= tgt;
      streaming_r <= streaming;
    end
    if (cmd.upd_mod) begin
      reu_mod_r <= reu_mod;
    end
  end

  // ---------------- sweep counter (clear and decay) ----------------
  always_comb begin
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    idx_nxt  = idx_r;
    if (cmd.sweep_rst) begin
      cnt_nxt  = '0;
      pend_nxt = 1'b0;
    end else if (cmd.clear_step) begin
      cnt_nxt = cnt_r + SWP_W'(1);
    end else if (cmd.decay_step) begin
      if (cnt_r != SWP_W'(SWEEP_LEN)) begin
        pend_nxt = 1'b1;
        idx_nxt  = cnt_r;
        cnt_nxt  = cnt_r + SWP_W'(1);
      end else begin
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
    idx_r <= idx_nxt;
  end

  // ---------------- store ports ----------------
  always_comb begin
    row_we    = 1'b0;
    row_waddr = set_idx;
    row_wdata = {sig_w, dead_w, rrpv_w};
    set_we    = 1'b0;
    set_waddr = set_idx;
    set_wdata = {in_r.physical_address, score_new};
    reu_we    = 1'b0;
    reu_waddr = tgt_r;
    reu_wdata = reu_mod;
    row_raddr = set_idx;
    reu_raddr = sig_cur;
    if (cmd.clear_step) begin
      row_we    = cnt_r < SWP_W'(SETS);
      row_waddr = cnt_r[SET_W-1:0];
      row_wdata = {{(WAYS*(SIG_W+2)){1'b0}}, {WAYS{sdrrip_pkg::RRPV_MAX}}};
      set_we    = cnt_r < SWP_W'(SETS);
      set_waddr = cnt_r[SET_W-1:0];
      set_wdata = '0;
      reu_we    = cnt_r < SWP_W'(SIG_COUNT);
      reu_waddr = cnt_r[SIG_W-1:0];
      reu_wdata = sdrrip_pkg::REUSE_RST;
    end else if (cmd.decay_step) begin
      row_raddr = cnt_r[SET_W-1:0];
      reu_raddr = cnt_r[SIG_W-1:0];
      row_we    = pend_r && (idx_r < SWP_W'(SETS));
      row_waddr = idx_r[SET_W-1:0];
      row_wdata = {sig_q, dead_dec, rrpv_q};
      reu_we    = pend_r && (idx_r < SWP_W'(SIG_COUNT));
      reu_waddr = idx_r[SIG_W-1:0];
      reu_wdata = (reu_rd == 2'd0) ? reu_rd : reu_rd - 2'd1;
    end else if (cmd.victim_done) begin
      row_we    = !inv_hit && !dead_hit;
      row_wdata = {sig_q, dead_q, aged};
    end else if (cmd.upd_exec) begin
      set_we    = 1'b1;
      reu_raddr = tgt;
    end else if (cmd.upd_mod) begin
      reu_we = 1'b1;
    end else if (cmd.upd_done) begin
      row_we = 1'b1;
    end
  end

  sdrrip_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rd)
  );

  sdrrip_ram #(.WIDTH(REC_W), .DEPTH(SETS)) u_set_ram (
    .clk   (clk),
    .we    (set_we),
    .waddr (set_waddr),
    .wdata (set_wdata),
    .raddr (set_idx),
    .rdata (set_rd)
  );

  sdrrip_ram #(.WIDTH(2), .DEPTH(SIG_COUNT)) u_reuse_ram (
    .clk   (clk),
    .we    (reu_we),
    .waddr (reu_waddr),
    .wdata (reu_wdata),
    .raddr (reu_raddr),
    .rdata (reu_rd)
  );

  // ---------------- config, global counters, result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= sdrrip_pkg::DECAY_PERIOD_RST;
      thr_r       <= sdrrip_pkg::STREAM_THR_RST;
      sel_r       <= SEL_HALF;
      tick_r      <= '0;
      cd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sdrrip_pkg::CFG_DECAY_PERIOD: period_r <= cfg_wdata;
          sdrrip_pkg::CFG_STREAM_THR:   thr_r    <= cfg_wdata[1:0];
          default:                      period_r <= period_r;
        endcase
      end
      if (cmd.upd_done) begin
        sel_r  <= sel_nxt;
        tick_r <= tick_nxt;
        cd_r   <= decay_due ? '0 : cd_inc[sdrrip_pkg::CFG_W-1:0];
      end
      if (cmd.victim_done || cmd.upd_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.victim_done) begin
      out_data_r.victim_way    <= sdrrip_pkg::WAY_IN_W'(vict_way);
      out_data_r.set_streaming <= 1'b0;
    end else if (cmd.upd_done) begin
      out_data_r.victim_way    <= '0;
      out_data_r.set_streaming <= streaming_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.is_update  = (in_r.command == sdrrip_pkg::CMD_UPDATE);
  assign sts.out_busy   = out_valid_r && !out_ready;
  assign sts.clear_last = (cnt_r == SWP_W'(SWEEP_LEN - 1));
  assign sts.sweep_done = pend_r && (idx_r == SWP_W'(SWEEP_LEN - 1));
  assign sts.decay_due  = decay_due;

endmodule

[rtl/ship_drrip_dead_block_replacement_unit.sv]
// ----------------------------------------------------------------------------
// ship_drrip_dead_block_replacement_unit
// Last-level cache replacement engine: SHiP reuse, dead blocks, DRRIP dueling.
// ----------------------------------------------------------------------------
// One word in, one word out. A victim word (command 0) reads the set's row and
// returns the first invalid way, else the first way whose dead counter is 3,
// else the first way at RRPV 3 after aging the row; it passes the READ and
// EXEC states, and its result is registered as it leaves EXEC. An update
// word (command 1) runs the stride stream detector, adjusts the signature
// reuse table (increment on hit, decrement of the line's old signature on
// miss), the line's dead counter, the PSEL counter and writes the new
// insertion RRPV; it passes READ, EXEC, MOD and DONE, and its result is
// registered as it leaves DONE. The pace is set by the single read
// and single write port of the per-set row store and of the reuse table, which
// are visited in sequence. A result still waiting in the output register holds
// the last step of the next word until it is taken. Once per decay interval
// (register 0, counted in updates) a decay sweep walks all rows and reuse
// entries, one per cycle, once that update's result is registered. After
// reset a clearing pass initializes the stores; in_ready stays low meanwhile,
// and configuration writes are taken at any time. A finished result waits in
// the output register, and the next word is accepted while it waits.
// ----------------------------------------------------------------------------
module ship_drrip_dead_block_replacement_unit #(
  parameter int SETS           = 2048,
  parameter int WAYS           = 16,
  parameter int LEADER_SETS    = 64,
  parameter int SELECTOR_BITS  = 10,
  parameter int SIGNATURE_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sdrrip_pkg::in_word_t  in_data,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output sdrrip_pkg::out_word_t out_data,
  // configuration writes
  input  logic                  cfg_we,
  input  sdrrip_pkg::cfg_idx_t  cfg_index,
  input  logic [sdrrip_pkg::CFG_W-1:0] cfg_wdata
);

  sdrrip_pkg::ctl_cmd_t cmd;
  sdrrip_pkg::dp_sts_t  sts;

  // sequencer
  sdrrip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores and arithmetic
  sdrrip_dp #(
    .SETS           (SETS),
    .WAYS           (WAYS),
    .LEADER_SETS    (LEADER_SETS),
    .SELECTOR_BITS  (SELECTOR_BITS),
    .SIGNATURE_BITS (SIGNATURE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

[rtl/sdrrip_chk.sv]
// ----------------------------------------------------------------------------
// sdrrip_chk
// Port-level checks of the replacement unit, bound to the top level.
// ----------------------------------------------------------------------------
module sdrrip_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sdrrip_pkg::out_word_t out_data
);

  // a reset always starts the clearing pass
  a_clear_after_rst: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted back to back");

  // a result only appears while the block is busy with a word
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind ship_drrip_dead_block_replacement_unit sdrrip_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[bench/ship_drrip_dead_block_replacement_unit_checker.sv]
// ----------------------------------------------------------------------------
// ship_drrip_dead_block_replacement_unit_checker
// Watches the command and result channels, predicts each result word from a
// behavioral copy of the replacement state and compares it field by field.
// ----------------------------------------------------------------------------
module ship_drrip_dead_block_replacement_unit_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  sdrrip_pkg::in_word_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  sdrrip_pkg::out_word_t out_data,
  input  logic                  cfg_we,
  input  sdrrip_pkg::cfg_idx_t  cfg_index,
  input  logic [sdrrip_pkg::CFG_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = 2048;
  localparam int NWAYS = 16;
  localparam int NLINES = NSETS * NWAYS;
  localparam int LEADERS = 64;
  localparam int NSIGS = 64;
  localparam logic [9:0] SEL_TOP = 10'd1023;
  localparam logic [9:0] SEL_MID = 10'd512;

  logic [1:0]                    rrpv [NLINES];
  logic [1:0]                    dead [NLINES];
  logic [5:0]                    sig_hist [NLINES];
  logic [1:0]                    reuse [NSIGS];
  logic [sdrrip_pkg::ADDR_W-1:0] addr_hist [NSETS];
  logic [1:0]                    score [NSETS];
  logic [9:0]                    psel;
  logic [4:0]                    tick;
  logic [19:0]                   countdown;
  logic [19:0]                   period;
  logic [1:0]                    stream_thr;

  sdrrip_pkg::out_word_t expected_q [$];

  function automatic logic [3:0] choose_victim(int set, logic [15:0] valid);
    int base;
    logic [1:0] top;
    base = set * NWAYS;
    top = 2'd0;
    for (int w = 0; w < NWAYS; w++)
      if (!valid[w]) return w[3:0];
    for (int w = 0; w < NWAYS; w++)
      if (dead[base + w] == sdrrip_pkg::CNT_MAX) return w[3:0];
    for (int w = 0; w < NWAYS; w++)
      if (rrpv[base + w] > top) top = rrpv[base + w];
    if (top < sdrrip_pkg::RRPV_MAX)
      for (int w = 0; w < NWAYS; w++) rrpv[base + w] += sdrrip_pkg::RRPV_MAX - top;
    for (int w = 0; w < NWAYS; w++)
      if (rrpv[base + w] == sdrrip_pkg::RRPV_MAX) return w[3:0];
    return 4'd0;
  endfunction

  function automatic logic train_line(int set, int way,
                                      logic [sdrrip_pkg::ADDR_W-1:0] pc,
                                      logic [sdrrip_pkg::ADDR_W-1:0] addr, logic hit);
    int line;
    logic [sdrrip_pkg::ADDR_W-1:0] prev, delta;
    logic [5:0] sig, old_sig;
    logic leader, brrip_leader, brrip, streaming;
    logic [1:0] ins;
    line = set * NWAYS + way;
    prev = addr_hist[set];
    sig = pc[7:2];
    old_sig = sig_hist[line];
    leader = set < LEADERS;
    brrip_leader = set >= LEADERS / 2;
    tick = tick + 5'd1;
    countdown = countdown + 20'd1;
    if (prev == '0) begin
      score[set] = 2'd0;
    end else begin
      delta = (addr > prev) ? addr - prev : prev - addr;
      if (delta == sdrrip_pkg::STRIDE_ONE || delta == sdrrip_pkg::STRIDE_TWO) begin
        if (score[set] < 2'd3) score[set]++;
      end else if (score[set] > 2'd0) begin
        score[set]--;
      end
    end
    addr_hist[set] = addr;
    streaming = score[set] >= stream_thr;
    if (hit) begin
      dead[line] = 2'd0;
      if (reuse[sig] < 2'd3) reuse[sig]++;
    end else begin
      if (dead[line] < 2'd3) dead[line]++;
      if (reuse[old_sig] > 2'd0) reuse[old_sig]--;
    end
    if (leader) begin
      if (!brrip_leader) begin
        if (hit && psel < SEL_TOP) psel++;
      end else if (!hit && psel > 10'd0) begin
        psel--;
      end
    end
    if (streaming) begin
      rrpv[line] = sdrrip_pkg::RRPV_MAX;
      dead[line] = sdrrip_pkg::CNT_MAX;
    end else begin
      brrip = leader ? brrip_leader : (psel < SEL_MID);
      ins = (brrip && tick == 5'd0) ? sdrrip_pkg::RRPV_MAX : sdrrip_pkg::RRPV_LONG;
      if (reuse[sig] >= 2'd2) ins = sdrrip_pkg::RRPV_NEAR;
      if (dead[line] >= 2'd2) ins = sdrrip_pkg::RRPV_MAX;
      rrpv[line] = ins;
      if (ins == sdrrip_pkg::RRPV_NEAR) dead[line] = 2'd0;
    end
    sig_hist[line] = sig;
    // zero period acts as one
    if (countdown >= period) begin
      countdown = 20'd0;
      for (int s = 0; s < NSIGS; s++) if (reuse[s] > 2'd0) reuse[s]--;
      for (int s = 0; s < NLINES; s++) if (dead[s] > 2'd0) dead[s]--;
    end
    return streaming;
  endfunction

  int mismatches;

  always @(posedge clk) begin
    sdrrip_pkg::out_word_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < NLINES; i++) begin
        rrpv[i] = sdrrip_pkg::RRPV_MAX; dead[i] = 2'd0; sig_hist[i] = 6'd0;
      end
      for (int i = 0; i < NSIGS; i++) reuse[i] = sdrrip_pkg::REUSE_RST;
      for (int i = 0; i < NSETS; i++) begin
        addr_hist[i] = '0; score[i] = 2'd0;
      end
      psel = SEL_MID; tick = 5'd0; countdown = 20'd0;
      period = sdrrip_pkg::DECAY_PERIOD_RST; stream_thr = sdrrip_pkg::STREAM_THR_RST;
      expected_q.delete();
      mismatches = 0;
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == sdrrip_pkg::CFG_DECAY_PERIOD) period = cfg_wdata;
        else if (cfg_index == sdrrip_pkg::CFG_STREAM_THR) stream_thr = cfg_wdata[1:0];
      end
      // result compare before new prediction: a word accepted now cannot
      // already be on the output
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got.victim_way !== want.victim_way ||
              got.set_streaming !== want.set_streaming) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected way %0d stream %0b, got way %0d stream %0b",
                       want.victim_way, want.set_streaming,
                       got.victim_way, got.set_streaming);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = '0;
        if (in_data.command == sdrrip_pkg::CMD_VICTIM)
          want.victim_way = choose_victim(int'(in_data.set_index), in_data.valid_mask);
        else
          want.set_streaming = train_line(int'(in_data.set_index),
                                          int'(in_data.way_index),
                                          in_data.program_counter,
                                          in_data.physical_address, in_data.hit);
        expected_q.push_back(want);
      end
      fail_count <= mismatches;
      pending_count <= expected_q.size();
    end
  end

endmodule

[bench/ship_drrip_dead_block_replacement_unit_test.sv]
// ----------------------------------------------------------------------------
// ship_drrip_dead_block_replacement_unit_test
// Drives directed and random victim/update words with random gaps and output
// stalls across several register settings; the checker does the scoring.
// ----------------------------------------------------------------------------
module ship_drrip_dead_block_replacement_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  sdrrip_pkg::in_word_t  in_data;
  sdrrip_pkg::out_word_t out_data;
  logic cfg_we;
  sdrrip_pkg::cfg_idx_t cfg_index;
  logic [sdrrip_pkg::CFG_W-1:0] cfg_wdata;
  int fail_count, pending_count;
  bit stall_on;

  ship_drrip_dead_block_replacement_unit u_dut (.*);

  ship_drrip_dead_block_replacement_unit_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // gap length: mostly short, now and then long, sometimes none
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls at random while enabled
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (!stall_on) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                      ($urandom_range(0, 9) == 0);
  end

  // per-set address streams so the stride detector fires often
  logic [sdrrip_pkg::ADDR_W-1:0] stream_base [8];

  // valid stays up across back-to-back words; acceptance is judged on the
  // values seen at the edge
  task automatic send_word(sdrrip_pkg::in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk iff in_ready);
  endtask

  task automatic write_reg(sdrrip_pkg::cfg_idx_t idx, logic [sdrrip_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected word, then let a possible decay sweep finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  function automatic sdrrip_pkg::in_word_t rand_word();
    sdrrip_pkg::in_word_t w;
    int k;
    w.command = sdrrip_pkg::cmd_code_t'($urandom_range(0, 1));
    k = $urandom_range(0, 7);
    // concentrate on a few sets, leaders included, so state builds up
    case ($urandom_range(0, 3))
      0: w.set_index = 11'($urandom_range(0, 63));
      1: w.set_index = 11'($urandom);
      default: w.set_index = 11'(k * 200 + (k < 4 ? k : 40));
    endcase
    w.way_index = 4'($urandom);
    w.valid_mask = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'hFFFF;
    w.program_counter = 48'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) w.program_counter[7:2] = 6'($urandom_range(0, 3));
    if ($urandom_range(0, 4) != 0) begin
      stream_base[k] = stream_base[k] + ($urandom_range(0, 1) ? 48'd64 : 48'd128);
      w.physical_address = stream_base[k];
      w.set_index = 11'(k * 200 + (k < 4 ? k : 40));
    end else begin
      w.physical_address = 48'({$urandom, $urandom});
    end
    w.hit = 1'($urandom);
    return w;
  endfunction

  initial begin
    sdrrip_pkg::in_word_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = sdrrip_pkg::CFG_DECAY_PERIOD;
    cfg_wdata = '0;
    stall_on = 1'b0;
    for (int i = 0; i < 8; i++) stream_base[i] = 48'({$urandom, $urandom}) & ~48'h3F;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, both commands, empty history, zero threshold
    write_reg(sdrrip_pkg::CFG_STREAM_THR, 20'd1);
    w = '0; w.command = sdrrip_pkg::CMD_VICTIM; w.valid_mask = 16'hFFFF; send_word(w);
    w.valid_mask = 16'h7FFF; w.set_index = '1; send_word(w);
    w.valid_mask = 16'hFFFE; send_word(w);
    w = '0; w.command = sdrrip_pkg::CMD_UPDATE; w.physical_address = 48'h1000;
    w.hit = 1'b1; send_word(w);
    w.physical_address = 48'h1040; send_word(w);
    w.physical_address = 48'h10C0; w.hit = 1'b0; send_word(w);
    w.physical_address = '1; w.program_counter = '1; w.way_index = '1; send_word(w);
    w.set_index = '1; w.physical_address = '0; send_word(w);
    w.set_index = 11'd32; w.hit = 1'b0; send_word(w);
    w.set_index = 11'd31; w.hit = 1'b1; send_word(w);
    for (int i = 0; i < 4; i++) begin
      w = '0; w.command = sdrrip_pkg::CMD_UPDATE; w.way_index = 4'(i); w.set_index = 11'd5;
      w.hit = 1'b0; w.physical_address = 48'h5000 + 48'(7 * i); send_word(w);
    end
    w = '0; w.command = sdrrip_pkg::CMD_VICTIM; w.set_index = 11'd5; w.valid_mask = 16'hFFFF;
    send_word(w);
    drain();
    write_reg(sdrrip_pkg::CFG_STREAM_THR, 20'd0);
    write_reg(sdrrip_pkg::CFG_DECAY_PERIOD, 20'd0);
    w = '0; w.command = sdrrip_pkg::CMD_UPDATE; w.set_index = 11'd9; send_word(w);
    w.command = sdrrip_pkg::CMD_VICTIM; w.valid_mask = 16'hFFFF; send_word(w);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(sdrrip_pkg::CFG_DECAY_PERIOD, 20'd1);
          write_reg(sdrrip_pkg::CFG_STREAM_THR, 20'd3);
        end
        1: begin
          write_reg(sdrrip_pkg::CFG_DECAY_PERIOD, 20'd37);
          write_reg(sdrrip_pkg::CFG_STREAM_THR, 20'd2);
        end
        2: begin
          write_reg(sdrrip_pkg::CFG_DECAY_PERIOD, 20'hFFFFF);
          write_reg(sdrrip_pkg::CFG_STREAM_THR, 20'd1);
        end
        default: begin
          write_reg(sdrrip_pkg::CFG_DECAY_PERIOD, 20'd5);
          write_reg(sdrrip_pkg::CFG_STREAM_THR, 20'd2);
        end
      endcase
      stall_on = (ph != 1);
      for (int i = 0; i < 100; i++) send_word(rand_word());
      drain();
    end

    if (fail_count == 0 && pending_count == 0)
      $display("ship_drrip_dead_block_replacement_unit regression: pass");
    else
      $display("ship_drrip_dead_block_replacement_unit regression: fail");
    $finish;
  end

  initial begin
    #100ms;
    $display("ship_drrip_dead_block_replacement_unit regression: fail");
    $finish;
  end
endmodule
